>>> rtl/mbt_pkg.sv
`default_nettype none
package mbt_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;
   // most dump beats emitted for one dump request
   localparam int DUMP_LIMIT = 32;
   localparam int DUMP_CNT_W = $clog2(DUMP_LIMIT + 1);

   localparam logic [1:0] OP_LEARN = 2'd0;
   localparam logic [1:0] OP_TICK  = 2'd1;
   localparam logic [1:0] OP_DUMP  = 2'd2;

   localparam logic [2:0] ST_UPDATED    = 3'd0;
   localparam logic [2:0] ST_INSERTED   = 3'd1;
   localparam logic [2:0] ST_FULL       = 3'd2;
   localparam logic [2:0] ST_DUMP_ENTRY = 3'd3;
   localparam logic [2:0] ST_DUMP_EMPTY = 3'd4;

   typedef struct packed {
      logic [1:0]  operation;
      logic [47:0] client_mac;
      logic [31:0] assigned_ip;
      logic [31:0] lease_seconds;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] entry_mac;
      logic [31:0] entry_ip;
      logic [31:0] seconds_left;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [47:0] mac;
      logic [31:0] ip;
      logic [31:0] timer;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LEARN_SCAN,
      S_LEARN_WRITE,
      S_TICK_SCAN,
      S_DUMP_SCAN,
      S_DUMP_FLUSH
   } state_type;

endpackage
`default_nettype wire

>>> rtl/mbt_cell.sv
`default_nettype none
// One table slot of the rotating chain; takes its neighbor's entry on shift.
module mbt_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift,
   input  wire mbt_pkg::entry_type nxt,
   output mbt_pkg::entry_type      cur
);

   logic        valid_ff, valid_in;
   logic [47:0] mac_ff,   mac_in;
   logic [31:0] ip_ff,    ip_in;
   logic [31:0] timer_ff, timer_in;

   always_comb begin
      valid_in = shift ? nxt.valid : valid_ff;
      mac_in   = shift ? nxt.mac   : mac_ff;
      ip_in    = shift ? nxt.ip    : ip_ff;
      timer_in = shift ? nxt.timer : timer_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff   <= mac_in;
      ip_ff    <= ip_in;
      timer_ff <= timer_in;
   end

   assign cur = '{valid: valid_ff, mac: mac_ff, ip: ip_ff, timer: timer_ff};

endmodule
`default_nettype wire

>>> rtl/mac_ip_binding_table_with_aging.sv
`default_nettype none
// MAC to IPv4 binding table with per-entry aging. The slots sit in a ring of
// TABLE_ENTRIES cells that rotates one cell per cycle while a request is in
// work and the response side does not hold it; all work is done at the head
// cell, which sees slot k at step k of a rotation, so every request costs
// whole rotations. One request is in work at a time. A learn beat takes one
// rotation to look for the MAC and a free slot and a second rotation to write;
// a tick beat ages every slot in one rotation and gives no response; a dump
// beat takes one rotation and a flush step, and the response side may stall
// both. The response goes through an output register, so the last response
// beat may wait there while the next request is already taken. Dump beats
// come out in slot order, at most 32, the final one flagged with last; an
// empty table dumps a single empty marker. Learn always answers with one beat.
module mac_ip_binding_table_with_aging #(
   parameter int TABLE_ENTRIES = mbt_pkg::TABLE_ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire mbt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output mbt_pkg::rsp_type      rsp_data
);

   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam logic [IW-1:0] LAST_SLOT = IW'(TABLE_ENTRIES - 1);
   localparam int CW = mbt_pkg::DUMP_CNT_W;

   // ring of slot cells; cell 0 is the head, the tail takes the processed head
   mbt_pkg::entry_type cell_q [TABLE_ENTRIES];
   mbt_pkg::entry_type head_mod;
   logic               shift;

   for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
      mbt_pkg::entry_type nxt;
      if (i == TABLE_ENTRIES - 1) begin : g_tail
         assign nxt = head_mod;
      end else begin : g_link
         assign nxt = cell_q[i+1];
      end
      mbt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (shift),
         .nxt   (nxt),
         .cur   (cell_q[i])
      );
   end

   mbt_pkg::entry_type head;
   assign head = cell_q[0];

   // control state
   mbt_pkg::state_type state_ff, state_in;
   logic [IW-1:0]      cnt_ff, cnt_in;
   logic               hit_ff, hit_in;
   logic [IW-1:0]      hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [IW-1:0]      free_idx_ff, free_idx_in;
   logic               held_vld_ff, held_vld_in;
   logic [CW-1:0]      n_ff, n_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   mbt_pkg::req_type   job_ff, job_in;
   mbt_pkg::entry_type held_ff, held_in;
   mbt_pkg::rsp_type   rsp_ff, rsp_in;

   logic accept, out_free, scan_end, take, tgt_here, learn_done;
   logic [IW-1:0] tgt_idx;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign scan_end = (cnt_ff == LAST_SLOT) && shift;
   // dump picks up a slot while the beat budget lasts
   assign take     = head.valid && (n_ff < CW'(mbt_pkg::DUMP_LIMIT));
   assign tgt_idx  = hit_ff ? hit_idx_ff : free_idx_ff;
   assign tgt_here = (hit_ff || free_ff) && (cnt_ff == tgt_idx);
   assign learn_done = (state_ff == mbt_pkg::S_LEARN_WRITE) && scan_end;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mbt_pkg::S_IDLE: begin
            if (accept) begin
               unique case (req_data.operation)
                  mbt_pkg::OP_LEARN: state_in = mbt_pkg::S_LEARN_SCAN;
                  mbt_pkg::OP_TICK:  state_in = mbt_pkg::S_TICK_SCAN;
                  mbt_pkg::OP_DUMP:  state_in = mbt_pkg::S_DUMP_SCAN;
                  default:           state_in = mbt_pkg::S_IDLE;
               endcase
            end
         end
         mbt_pkg::S_LEARN_SCAN:  if (scan_end) state_in = mbt_pkg::S_LEARN_WRITE;
         mbt_pkg::S_LEARN_WRITE: if (scan_end) state_in = mbt_pkg::S_IDLE;
         mbt_pkg::S_TICK_SCAN:   if (scan_end) state_in = mbt_pkg::S_IDLE;
         mbt_pkg::S_DUMP_SCAN:   if (scan_end) state_in = mbt_pkg::S_DUMP_FLUSH;
         mbt_pkg::S_DUMP_FLUSH:  if (out_free) state_in = mbt_pkg::S_IDLE;
         default:                state_in = mbt_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready    = (state_ff == mbt_pkg::S_IDLE);
      shift        = 1'b0;
      head_mod     = head;
      cnt_in       = cnt_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      held_vld_in  = held_vld_ff;
      held_in      = held_ff;
      n_in         = n_ff;
      job_in       = job_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         mbt_pkg::S_IDLE: begin
            if (accept) begin
               job_in      = req_data;
               cnt_in      = '0;
               hit_in      = 1'b0;
               free_in     = 1'b0;
               n_in        = '0;
               held_vld_in = 1'b0;
            end
         end
         mbt_pkg::S_LEARN_SCAN: begin
            shift = 1'b1;
            if (head.valid && !hit_ff && (head.mac == job_ff.client_mac)) begin
               hit_in     = 1'b1;
               hit_idx_in = cnt_ff;
            end
            if (!head.valid && !free_ff) begin
               free_in     = 1'b1;
               free_idx_in = cnt_ff;
            end
         end
         mbt_pkg::S_LEARN_WRITE: begin
            // the final step also loads the response beat
            shift = (cnt_ff != LAST_SLOT) || out_free;
            if (tgt_here) begin
               head_mod = '{valid: 1'b1, mac: job_ff.client_mac,
                            ip: job_ff.assigned_ip, timer: job_ff.lease_seconds};
            end
         end
         mbt_pkg::S_TICK_SCAN: begin
            shift          = 1'b1;
            head_mod.valid = head.valid && (head.timer > 32'd1);
            head_mod.timer = head.timer - 32'd1;
         end
         mbt_pkg::S_DUMP_SCAN: begin
            // a found slot pushes the held one out, which needs the output free
            shift = !(take && held_vld_ff) || out_free;
            if (shift && take) begin
               if (held_vld_ff) begin
                  rsp_in = '{status: mbt_pkg::ST_DUMP_ENTRY, entry_mac: held_ff.mac,
                             entry_ip: held_ff.ip, seconds_left: held_ff.timer,
                             last: 1'b0};
                  rsp_valid_in = 1'b1;
               end
               held_in     = head;
               held_vld_in = 1'b1;
               n_in        = n_ff + CW'(1);
            end
         end
         mbt_pkg::S_DUMP_FLUSH: begin
            if (out_free) begin
               if (held_vld_ff) begin
                  rsp_in = '{status: mbt_pkg::ST_DUMP_ENTRY, entry_mac: held_ff.mac,
                             entry_ip: held_ff.ip, seconds_left: held_ff.timer,
                             last: 1'b1};
               end else begin
                  rsp_in = '{status: mbt_pkg::ST_DUMP_EMPTY, entry_mac: 48'd0,
                             entry_ip: 32'd0, seconds_left: 32'd0, last: 1'b1};
               end
               rsp_valid_in = 1'b1;
               held_vld_in  = 1'b0;
            end
         end
         default: begin
            shift = 1'b0;
         end
      endcase

      if (shift) begin
         cnt_in = (cnt_ff == LAST_SLOT) ? '0 : cnt_ff + IW'(1);
      end

      if (learn_done) begin
         rsp_in.entry_mac = job_ff.client_mac;
         rsp_in.entry_ip  = job_ff.assigned_ip;
         rsp_in.last      = 1'b1;
         if (hit_ff) begin
            rsp_in.status       = mbt_pkg::ST_UPDATED;
            rsp_in.seconds_left = job_ff.lease_seconds;
         end else if (free_ff) begin
            rsp_in.status       = mbt_pkg::ST_INSERTED;
            rsp_in.seconds_left = job_ff.lease_seconds;
         end else begin
            rsp_in.status       = mbt_pkg::ST_FULL;
            rsp_in.seconds_left = 32'd0;
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mbt_pkg::S_IDLE;
         cnt_ff       <= '0;
         hit_ff       <= 1'b0;
         hit_idx_ff   <= '0;
         free_ff      <= 1'b0;
         free_idx_ff  <= '0;
         held_vld_ff  <= 1'b0;
         n_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         hit_ff       <= hit_in;
         hit_idx_ff   <= hit_idx_in;
         free_ff      <= free_in;
         free_idx_ff  <= free_idx_in;
         held_vld_ff  <= held_vld_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // nothing may be held over from a dump once the block is idle
   a_idle_no_held: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !held_vld_ff)
      else $error("held dump entry left over in idle");

   // a learn search rotation steps one slot per cycle
   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mbt_pkg::S_LEARN_SCAN) && (cnt_ff != LAST_SLOT)
      |=> cnt_ff == $past(cnt_ff) + IW'(1))
      else $error("learn scan skipped a slot");

   // learn and empty-dump beats always close their request
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_ff.status != mbt_pkg::ST_DUMP_ENTRY) |-> rsp_ff.last)
      else $error("single-beat response without last");

   // dump beat budget never exceeded
   a_dump_budget: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CW'(mbt_pkg::DUMP_LIMIT))
      else $error("dump beat count overflow");
`endif

endmodule
`default_nettype wire
